### hw/rtl/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// rsmp_pkg
// Shared types and constants of the reservoir sampler: opcodes, field widths,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rsmp_pkg;

    localparam int OP_W     = 2;
    localparam int PORT_W   = 32;
    localparam int COUNT_W  = 11;
    localparam int DIV_W    = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam logic [COUNT_W-1:0] TARGET_RESET = 11'd1024;
    localparam logic [DIV_W-1:0]   POOL_MAX     = '1;

    typedef enum logic [OP_W-1:0] {
        OP_OFFER  = 2'd0,
        OP_REWIND = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef struct packed {
        logic offer_append;
        logic offer_divide;
        logic rewind;
        logic read;
        logic clear;
        logic replace;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic fill_ok;
        logic div_done;
    } t_status;

endpackage

### hw/rtl/rsmp_divider.sv
// ----------------------------------------------------------------------------
// rsmp_divider
// Radix-2 restoring remainder unit: one quotient bit per cycle, pulses done
// with the remainder of dividend by divisor.
// ----------------------------------------------------------------------------
module rsmp_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rsmp_pkg::DIV_W-1:0] i_dividend,
    input  logic [rsmp_pkg::DIV_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [rsmp_pkg::DIV_W-1:0] o_remainder
);
    import rsmp_pkg::*;

    logic                 r_active;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_dvd;
    logic [DIV_W-1:0]     r_dsr;
    logic [DIV_W:0]       w_trial;
    logic [DIV_W-1:0]     n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DIV_W-1]};
        if (w_trial >= {1'b0, r_dsr}) begin
            n_rem = DIV_W'(w_trial - {1'b0, r_dsr});
        end else begin
            n_rem = DIV_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
                r_rem    <= '0;
                r_dvd    <= i_dividend;
                r_dsr    <= i_divisor;
            end else if (r_active) begin
                r_rem <= n_rem;
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

### hw/rtl/rsmp_datapath.sv
// ----------------------------------------------------------------------------
// rsmp_datapath
// Slot memory, counters, target register, remainder unit and result
// registers of the reservoir sampler, driven by controller commands.
// ----------------------------------------------------------------------------
module rsmp_datapath #(
    parameter int CAPACITY     = 1024,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rsmp_pkg::t_cmd               i_cmd,
    output rsmp_pkg::t_status            o_status,
    input  logic [rsmp_pkg::PORT_W-1:0]  i_item_handle,
    input  logic [rsmp_pkg::PORT_W-1:0]  i_random_value,
    input  logic                         i_cfg_we,
    input  logic [rsmp_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic [rsmp_pkg::PORT_W-1:0]  o_read_handle,
    output logic                         o_read_valid,
    output logic                         o_at_end,
    output logic [rsmp_pkg::COUNT_W-1:0] o_stored_count,
    output logic                         o_replaced
);
    import rsmp_pkg::*;

    localparam int LIM_MAX = (CAPACITY < 2047) ? CAPACITY : 2047;
    localparam int CNT_W   = $clog2(LIM_MAX + 1);
    localparam int IDX_W   = $clog2(CAPACITY);

    logic [HANDLE_WIDTH-1:0] r_slots [CAPACITY];
    logic [HANDLE_WIDTH-1:0] r_mem_q;
    logic [HANDLE_WIDTH-1:0] r_handle;
    logic [COUNT_W-1:0]      r_target;
    logic [CNT_W-1:0]        r_filled;
    logic [CNT_W-1:0]        r_rdpos;
    logic [DIV_W-1:0]        r_pool;
    logic                    r_rd_ok;
    logic                    r_stored;

    logic [CNT_W-1:0]        w_limit;
    logic [DIV_W-1:0]        w_pool_next;
    logic [DIV_W-1:0]        w_rem;
    logic                    w_div_done;
    logic                    w_hit;
    logic                    w_can_read;
    logic                    w_we;
    logic [IDX_W-1:0]        w_waddr;
    logic [HANDLE_WIDTH-1:0] w_wdata;

    rsmp_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.offer_divide),
        .i_dividend  (i_random_value),
        .i_divisor   (w_pool_next),
        .o_done      (w_div_done),
        .o_remainder (w_rem)
    );

    always_comb begin
        if (32'(r_target) < 32'(CAPACITY)) begin
            w_limit = CNT_W'(r_target);
        end else begin
            w_limit = CNT_W'(CAPACITY);
        end
        w_pool_next = (r_pool == POOL_MAX) ? r_pool : r_pool + 1'b1;
        w_hit       = (w_rem < 32'(r_filled)) && (w_rem < 32'(w_limit));
        w_can_read  = r_rdpos < r_filled;
        w_we        = i_cmd.offer_append || (i_cmd.replace && w_hit);
        if (i_cmd.offer_append) begin
            w_waddr = IDX_W'(r_filled);
            w_wdata = HANDLE_WIDTH'(i_item_handle);
        end else begin
            w_waddr = IDX_W'(w_rem);
            w_wdata = r_handle;
        end
    end

    assign o_status.fill_ok  = r_filled < w_limit;
    assign o_status.div_done = w_div_done;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_slots[w_waddr] <= w_wdata;
        end
        if (i_cmd.read && w_can_read) begin
            r_mem_q <= r_slots[IDX_W'(r_rdpos)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RESET;
            r_filled <= '0;
            r_rdpos  <= '0;
            r_pool   <= '0;
            r_rd_ok  <= 1'b0;
            r_stored <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (i_cmd.offer_append || i_cmd.offer_divide) begin
                r_pool   <= w_pool_next;
                r_rd_ok  <= 1'b0;
                r_stored <= i_cmd.offer_append;
            end
            if (i_cmd.offer_append) begin
                r_filled <= r_filled + 1'b1;
            end
            if (i_cmd.offer_divide) begin
                r_handle <= HANDLE_WIDTH'(i_item_handle);
            end
            if (i_cmd.replace) begin
                r_stored <= w_hit;
            end
            if (i_cmd.rewind) begin
                r_rdpos  <= '0;
                r_rd_ok  <= 1'b0;
                r_stored <= 1'b0;
            end
            if (i_cmd.read) begin
                r_rd_ok  <= w_can_read;
                r_stored <= 1'b0;
                if (w_can_read) begin
                    r_rdpos <= r_rdpos + 1'b1;
                end
            end
            if (i_cmd.clear) begin
                r_filled <= '0;
                r_pool   <= '0;
                r_rdpos  <= '0;
                r_rd_ok  <= 1'b0;
                r_stored <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_read_handle  <= r_rd_ok ? PORT_W'(r_mem_q) : '0;
            o_read_valid   <= r_rd_ok;
            o_at_end       <= r_rdpos >= r_filled;
            o_stored_count <= COUNT_W'(r_filled);
            o_replaced     <= r_stored;
        end
    end

endmodule

### hw/rtl/rsmp_ctrl.sv
// ----------------------------------------------------------------------------
// rsmp_ctrl
// Controller of the reservoir sampler: decodes the opcode, sequences the
// remainder wait and replacement, and strobes each result.
// ----------------------------------------------------------------------------
module rsmp_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [rsmp_pkg::OP_W-1:0] i_opcode,
    input  rsmp_pkg::t_status         i_status,
    output rsmp_pkg::t_cmd            o_cmd,
    output logic                      o_done
);
    import rsmp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_REPL,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   w_accept;

    assign w_accept = start && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EMIT;
                    unique case (t_op'(i_opcode))
                        OP_OFFER: begin
                            if (i_status.fill_ok) begin
                                o_cmd.offer_append = 1'b1;
                            end else begin
                                o_cmd.offer_divide = 1'b1;
                                n_state            = S_DIV;
                            end
                        end
                        OP_REWIND: o_cmd.rewind = 1'b1;
                        OP_READ:   o_cmd.read   = 1'b1;
                        OP_CLEAR:  o_cmd.clear  = 1'b1;
                    endcase
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_REPL;
                end
            end
            S_REPL: begin
                o_cmd.replace = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_EMIT);
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !busy)
        else $error("result strobe while busy");

    a_full_offer_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.offer_divide |=> (r_state == S_DIV))
        else $error("full offer did not wait on remainder");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_DIV))
        else $error("remainder done outside wait");

    a_emit_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> !o_cmd.emit)
        else $error("two emits in a row");

endmodule

### hw/rtl/reservoir_sampler_unit.sv
// ----------------------------------------------------------------------------
// reservoir_sampler_unit
// Reservoir sampler keeping a uniform sample of item handles from a stream.
// ----------------------------------------------------------------------------
// Usage:
//   Present opcode, item_handle and random_value with start; the item is
//   taken at a clock edge where start is high and busy is low.
//   Opcodes: offer, rewind read position, read next, clear reservoir.
//   Each item gives one result, shown for a single cycle with o_done high;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Rewind, read, clear and an offer while the reservoir is filling go from
//   the accepting edge to S_EMIT, which registers the result and raises
//   o_done; an offer once it is full first waits in S_DIV for the radix-2
//   remainder unit (one bit per cycle, 32 steps), then for its completion
//   flag, the replacement write in S_REPL and the result register in S_EMIT.
//   busy is low again in the o_done cycle, so a new item may start then.
//   target_size is written through i_cfg_we / i_cfg_wdata while idle.
//   Reset zeroes counts and read position and sets target_size to 1024; slot
//   contents are undefined until written and need no clearing pass.
// ----------------------------------------------------------------------------
module reservoir_sampler_unit #(
    parameter int CAPACITY     = 1024,
    parameter int HANDLE_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rsmp_pkg::OP_W-1:0]    i_opcode,
    input  logic [rsmp_pkg::PORT_W-1:0]  i_item_handle,
    input  logic [rsmp_pkg::PORT_W-1:0]  i_random_value,
    input  logic                         i_cfg_we,
    input  logic [rsmp_pkg::COUNT_W-1:0] i_cfg_wdata,
    output logic                         o_done,
    output logic [rsmp_pkg::PORT_W-1:0]  o_read_handle,
    output logic                         o_read_valid,
    output logic                         o_at_end,
    output logic [rsmp_pkg::COUNT_W-1:0] o_stored_count,
    output logic                         o_replaced
);
    import rsmp_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    rsmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_opcode (i_opcode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_done   (o_done)
    );

    rsmp_datapath #(
        .CAPACITY     (CAPACITY),
        .HANDLE_WIDTH (HANDLE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_item_handle  (i_item_handle),
        .i_random_value (i_random_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_read_handle  (o_read_handle),
        .o_read_valid   (o_read_valid),
        .o_at_end       (o_at_end),
        .o_stored_count (o_stored_count),
        .o_replaced     (o_replaced)
    );

endmodule

### tb/reservoir_sampler_unit_test.sv
// ----------------------------------------------------------------------------
// reservoir_sampler_unit_test
// Drives offer, rewind, read and clear items into the reservoir sampler and
// checks every result against a behavioral copy of the reservoir: slot store,
// fill and pool counts, read position and target size. Targets of zero, one,
// the reset value and above capacity are covered, with one full-capacity fill,
// and the sender idles at random between items.
// ----------------------------------------------------------------------------
module reservoir_sampler_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rsmp_pkg::*;

    localparam int CAPACITY = 1024;

    typedef struct {
        logic [PORT_W-1:0]  handle;
        logic               valid;
        logic               at_end;
        logic [COUNT_W-1:0] count;
        logic               replaced;
    } t_sample;

    class reservoir_scoreboard;
        logic [PORT_W-1:0]  slot_mem [CAPACITY];
        int unsigned        filled;
        int unsigned        rd_pos;
        logic [DIV_W-1:0]   pool;
        logic [COUNT_W-1:0] target;
        t_sample            expected_q [$];
        int unsigned        errors;

        function new();
            filled = 0;
            rd_pos = 0;
            pool   = '0;
            target = TARGET_RESET;
            errors = 0;
        endfunction

        function void write_target(logic [COUNT_W-1:0] value);
            target = value;
        endfunction

        function void note_item(t_op op, logic [PORT_W-1:0] hdl, logic [PORT_W-1:0] rnd);
            int unsigned      limit;
            logic [DIV_W-1:0] idx;
            t_sample          s;
            limit = (target < CAPACITY) ? target : CAPACITY;
            s.handle   = '0;
            s.valid    = 1'b0;
            s.replaced = 1'b0;
            case (op)
                OP_OFFER: begin
                    if (pool != POOL_MAX) pool++;
                    if (filled < limit) begin
                        slot_mem[filled] = hdl;
                        filled++;
                        s.replaced = 1'b1;
                    end else begin
                        idx = rnd % pool;
                        if (idx < limit && idx < filled) begin
                            slot_mem[idx] = hdl;
                            s.replaced = 1'b1;
                        end
                    end
                end
                OP_REWIND: rd_pos = 0;
                OP_READ: begin
                    if (rd_pos < filled) begin
                        s.handle = slot_mem[rd_pos];
                        s.valid  = 1'b1;
                        rd_pos++;
                    end
                end
                default: begin
                    filled = 0;
                    pool   = '0;
                    rd_pos = 0;
                end
            endcase
            s.at_end = (rd_pos >= filled);
            s.count  = COUNT_W'(filled);
            expected_q.insert(expected_q.size(), s);
        endfunction

        task report(string msg);
            $display("mismatch at %0t ns: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_sample got);
            t_sample want;
            if (expected_q.size() == 0) begin
                report("result with no item pending");
                return;
            end
            want = expected_q.pop_front();
            if (got.handle !== want.handle)
                report($sformatf("read_handle %h, want %h", got.handle, want.handle));
            if (got.valid !== want.valid)
                report($sformatf("read_valid %b, want %b", got.valid, want.valid));
            if (got.at_end !== want.at_end)
                report($sformatf("at_end %b, want %b", got.at_end, want.at_end));
            if (got.count !== want.count)
                report($sformatf("stored_count %0d, want %0d", got.count, want.count));
            if (got.replaced !== want.replaced)
                report($sformatf("replaced %b, want %b", got.replaced, want.replaced));
        endtask
    endclass

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    i_opcode       = '0;
    logic [PORT_W-1:0]  i_item_handle  = '0;
    logic [PORT_W-1:0]  i_random_value = '0;
    logic               i_cfg_we       = 1'b0;
    logic [COUNT_W-1:0] i_cfg_wdata    = '0;
    logic               o_done;
    logic [PORT_W-1:0]  o_read_handle;
    logic               o_read_valid;
    logic               o_at_end;
    logic [COUNT_W-1:0] o_stored_count;
    logic               o_replaced;

    reservoir_scoreboard sb = new();
    t_sample             observed;
    int                  idle_pct = 0;

    reservoir_sampler_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_item_handle  (i_item_handle),
        .i_random_value (i_random_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_read_handle  (o_read_handle),
        .o_read_valid   (o_read_valid),
        .o_at_end       (o_at_end),
        .o_stored_count (o_stored_count),
        .o_replaced     (o_replaced)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            observed.handle   = o_read_handle;
            observed.valid    = o_read_valid;
            observed.at_end   = o_at_end;
            observed.count    = o_stored_count;
            observed.replaced = o_replaced;
            sb.check_result(observed);
        end
    end

    task automatic send_item(t_op op, logic [PORT_W-1:0] hdl, logic [PORT_W-1:0] rnd);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start          <= 1'b1;
        i_opcode       <= op;
        i_item_handle  <= hdl;
        i_random_value <= rnd;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_item(op, hdl, rnd);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_target(logic [COUNT_W-1:0] value);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_target(value);
    endtask

    task automatic run_phase(logic [COUNT_W-1:0] tgt, int n, int pct);
        t_op               op;
        int                pick;
        logic [PORT_W-1:0] rnd;
        write_target(tgt);
        idle_pct = pct;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 56)      op = OP_OFFER;
            else if (pick < 86) op = OP_READ;
            else if (pick < 96) op = OP_REWIND;
            else                op = OP_CLEAR;
            rnd = ($urandom_range(1) != 0) ? $urandom : $urandom_range(0, 31);
            send_item(op, $urandom, rnd);
        end
    endtask

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset target: empty reads, extreme handles and random words
        send_item(OP_READ, '0, '0);
        send_item(OP_REWIND, '0, '0);
        send_item(OP_OFFER, '0, '0);
        send_item(OP_OFFER, '1, '1);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_REWIND, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_CLEAR, '0, '0);

        // zero target: offers only count
        write_target('0);
        send_item(OP_OFFER, 32'hA5A5_A5A5, '0);
        send_item(OP_OFFER, 32'h5A5A_5A5A, '1);
        send_item(OP_READ, '0, '0);

        // single slot: append, then replace or drop by the random index
        write_target(11'd1);
        send_item(OP_OFFER, 32'h0000_0001, '0);
        send_item(OP_OFFER, 32'h8000_0000, '0);
        send_item(OP_OFFER, 32'hFFFF_0000, '1);
        send_item(OP_OFFER, 32'h0000_FFFF, 32'd1);
        send_item(OP_REWIND, '0, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_READ, '0, '0);

        // target above capacity
        write_target('1);
        send_item(OP_OFFER, 32'h1234_5678, '1);
        send_item(OP_OFFER, 32'h8765_4321, '0);
        send_item(OP_READ, '0, '0);
        send_item(OP_CLEAR, '0, '0);

        run_phase(11'd4, 16, 0);
        run_phase(11'd1, 12, 58);
        run_phase(11'd7, 12, 0);

        // fill to capacity under an oversized target, then read the head
        write_target('1);
        idle_pct = 26;
        send_item(OP_CLEAR, '0, '0);
        repeat (CAPACITY + 8) send_item(OP_OFFER, $urandom, $urandom);
        send_item(OP_REWIND, '0, '0);
        repeat (8) send_item(OP_READ, '0, '0);

        // lowered target keeps the full store
        run_phase(11'd5, 12, 26);
        run_phase(11'd0, 6, 58);
        run_phase(11'd16, 16, 0);
        run_phase(TARGET_RESET, 8, 58);
        run_phase(11'd3, 12, 26);

        start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
